/* rtl/core/rle_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rle_pkg;

  // list depth and the widths that follow from it
  localparam int CAPACITY = 32;
  localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW       = $clog2(CAPACITY + 1);

  // action codes
  typedef enum logic [2:0] {
    ACT_APPEND  = 3'd0,
    ACT_INSERT  = 3'd1,
    ACT_SEARCH  = 3'd2,
    ACT_DEL_POS = 3'd3,
    ACT_DEL_KEY = 3'd4,
    ACT_CLEAR   = 3'd5
  } action_e;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_MISS  = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RANGE = 2'd3
  } status_e;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_UP_START,
    S_UP,
    S_DN_START,
    S_DN,
    S_PUT,
    S_DROP,
    S_RESP
  } state_e;

  // input item
  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] key;
    logic [7:0]         age;
    logic [7:0]         children;
    logic [4:0]         position;
  } item_t;

  // result item
  typedef struct packed {
    logic [1:0] status;
    logic [4:0] found_position;
    logic [5:0] entry_total;
    logic       is_empty;
  } result_t;

  // one stored record
  typedef struct packed {
    logic signed [31:0] key;
    logic [7:0]         age;
    logic [7:0]         children;
  } rec_t;

  // record memory request
  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    rec_t          wdata;
    logic [AW-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

/* rtl/core/rle_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module rle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                        wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/core/rle_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module rle_ctrl import rle_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start_i,
  input  wire item_t item_i,
  input  wire rec_t  rd_data_i,
  output logic       busy_o,
  output logic       done_o,
  output result_t    result_o,
  output mem_req_t   mem_req_o
);

  state_e             state_q, state_d;
  action_e            act_q;
  logic signed [31:0] key_q;
  logic [7:0]         age_q, chl_q;
  logic [AW-1:0]      idx_q, idx_d;
  logic [AW-1:0]      slot_q, slot_d;
  logic [AW-1:0]      found_q, found_d;
  status_e            status_q, status_d;
  logic [CW-1:0]      count_q, count_d;

  logic    accept;
  action_e act_in;
  logic    full, empty, pos_ok, pos_last;
  logic    scan_hit, scan_last, up_done, dn_last;

  // shared decisions
  assign accept    = start_i && (state_q == S_IDLE);
  assign act_in    = action_e'(item_i.action);
  assign full      = (count_q == CW'(CAPACITY));
  assign empty     = (count_q == '0);
  assign pos_ok    = (32'(item_i.position) < 32'(count_q));
  assign pos_last  = ((32'(item_i.position) + 32'd1) == 32'(count_q));
  assign scan_hit  = (act_q == ACT_INSERT) ? !(rd_data_i.key < key_q)
                                           : (rd_data_i.key == key_q);
  assign scan_last = ((CW'(idx_q) + CW'(1)) == count_q);
  assign up_done   = (idx_q == slot_q);
  assign dn_last   = ((CW'(idx_q) + CW'(2)) == count_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (act_in)
            ACT_APPEND:  state_d = full ? S_RESP : S_PUT;
            ACT_INSERT: begin
              priority if (full) state_d = S_RESP;
              else if (empty)    state_d = S_PUT;
              else               state_d = S_SCAN;
            end
            ACT_SEARCH,
            ACT_DEL_KEY: state_d = empty ? S_RESP : S_SCAN;
            ACT_DEL_POS: begin
              priority if (!pos_ok) state_d = S_RESP;
              else if (pos_last)    state_d = S_DROP;
              else                  state_d = S_DN_START;
            end
            default:     state_d = S_RESP;
          endcase
        end
      end
      S_SCAN: begin
        priority if (scan_hit) begin
          unique case (act_q)
            ACT_INSERT:  state_d = S_UP_START;
            ACT_DEL_KEY: state_d = scan_last ? S_DROP : S_DN_START;
            default:     state_d = S_RESP;
          endcase
        end else if (scan_last) begin
          state_d = (act_q == ACT_INSERT) ? S_PUT : S_RESP;
        end
      end
      S_UP_START: state_d = S_UP;
      S_UP:       state_d = up_done ? S_PUT : S_UP;
      S_DN_START: state_d = S_DN;
      S_DN:       state_d = dn_last ? S_DROP : S_DN;
      S_PUT:      state_d = S_RESP;
      S_DROP:     state_d = S_RESP;
      S_RESP:     state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // memory requests, cursors, count and status
  always_comb begin
    idx_d     = idx_q;
    slot_d    = slot_q;
    found_d   = found_q;
    status_d  = status_q;
    count_d   = count_q;
    mem_req_o = '0;
    unique case (state_q)
      S_IDLE: begin
        // head entry is read ahead for a scan
        if (accept) begin
          status_d = STAT_OK;
          found_d  = '0;
          idx_d    = '0;
          unique case (act_in)
            ACT_APPEND: begin
              if (full) status_d = STAT_FULL;
              slot_d = AW'(count_q);
            end
            ACT_INSERT: begin
              if (full) status_d = STAT_FULL;
              slot_d = '0;
            end
            ACT_SEARCH,
            ACT_DEL_KEY: begin
              if (empty) status_d = STAT_MISS;
            end
            ACT_DEL_POS: begin
              if (!pos_ok) status_d = STAT_RANGE;
              slot_d = AW'(item_i.position);
            end
            ACT_CLEAR:   count_d = '0;
            default:     ;
          endcase
        end
      end
      S_SCAN: begin
        // compare the entry at idx while the next one is read
        mem_req_o.raddr = idx_q + AW'(1);
        priority if (scan_hit) begin
          slot_d = idx_q;
          if (act_q == ACT_SEARCH) found_d = idx_q;
        end else if (scan_last) begin
          if (act_q == ACT_INSERT) slot_d = AW'(count_q);
          else                     status_d = STAT_MISS;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      S_UP_START: begin
        mem_req_o.raddr = AW'(count_q - CW'(1));
        idx_d           = AW'(count_q - CW'(1));
      end
      S_UP: begin
        // move entry idx one place toward the tail
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = idx_q + AW'(1);
        mem_req_o.wdata = rd_data_i;
        mem_req_o.raddr = idx_q - AW'(1);
        if (!up_done) idx_d = idx_q - AW'(1);
      end
      S_DN_START: begin
        mem_req_o.raddr = slot_q + AW'(1);
        idx_d           = slot_q;
      end
      S_DN: begin
        // move entry idx+1 one place toward the head
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = idx_q;
        mem_req_o.wdata = rd_data_i;
        mem_req_o.raddr = idx_q + AW'(2);
        if (!dn_last) idx_d = idx_q + AW'(1);
      end
      S_PUT: begin
        mem_req_o.we       = 1'b1;
        mem_req_o.waddr    = slot_q;
        mem_req_o.wdata    = '{key: key_q, age: age_q, children: chl_q};
        count_d            = count_q + CW'(1);
      end
      S_DROP:  count_d = count_q - CW'(1);
      S_RESP:  ;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // item and cursor registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= act_in;
      key_q <= item_i.key;
      age_q <= item_i.age;
      chl_q <= item_i.children;
    end
    idx_q    <= idx_d;
    slot_q   <= slot_d;
    found_q  <= found_d;
    status_q <= status_d;
  end

  // result strobe
  assign busy_o                  = (state_q != S_IDLE);
  assign done_o                  = (state_q == S_RESP);
  assign result_o.status         = status_q;
  assign result_o.found_position = 5'(found_q);
  assign result_o.entry_total    = 6'(count_q);
  assign result_o.is_empty       = empty;

endmodule

`default_nettype wire

/* rtl/core/record_list_engine_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Ordered record list of up to CAPACITY entries held packed in one record
// memory. An item is taken when start is high and busy is low; busy then
// stays high until the result has been shown. The result appears on
// result_o for exactly one cycle with done_o high and must be taken then,
// as the block cannot hold it. Clear, spare codes, full refusals, range
// errors and lookups in an empty list show their result in the first cycle
// after acceptance; append, an insert into an empty list and a delete of
// the last record by position first pass through the put or drop state.
// Search, delete by key and sorted insert scan one entry per cycle, and
// inserts and deletes then move one entry per cycle. The worst item is a
// sorted insert at the head of a list one short of full, or a delete by key
// of the head of a full list. The single read and single write port of the
// record memory set that worst case.
module record_list_engine_unit import rle_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start,
  output logic       busy,
  input  wire item_t item_i,
  output logic       done_o,
  output result_t    result_o
);

  mem_req_t mem_req;
  rec_t     rd_data;

  // list sequencer
  rle_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .item_i    (item_i),
    .rd_data_i (rd_data),
    .busy_o    (busy),
    .done_o    (done_o),
    .result_o  (result_o),
    .mem_req_o (mem_req)
  );

  // record memory
  rle_ram #(
    .WIDTH ($bits(rec_t)),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (rd_data)
  );

`ifndef SYNTHESIS
  // a result is followed by readiness for the next item
  a_done_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("busy after result");

  // an accepted item always starts work
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item not started");

  // a result only ends a busy period
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result outside an item");

  // a full refusal reports a full list
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_o.status == STAT_FULL)) |->
      (result_o.entry_total == 6'(CAPACITY)))
    else $error("full status with room left");

  // a record memory write never lands past the list capacity
  a_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.we |-> (32'(mem_req.waddr) < CAPACITY))
    else $error("write outside the list");
`endif

endmodule

`default_nettype wire

/* tb/sv/record_list_checker.sv */
`timescale 1ns / 1ps

// watches the item and result channels of the list engine, keeps a shadow
// copy of the list, and compares every result with the oldest prediction
module record_list_checker import rle_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start_i,
  input  wire logic    busy_i,
  input  wire item_t   item_i,
  input  wire logic    done_i,
  input  wire result_t result_i,
  output int           pending_o,
  output int           fail_count_o
);

  // shadow list, packed from the head at slot 0
  rec_t        list_rec [CAPACITY];
  int unsigned list_len;

  // predicted replies, oldest first
  result_t     reply_q [$];
  int          mismatch_total;
  int          result_index;

  // one line per mismatch
  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatch_total++;
    $display("%0t: result %0d: %s: got %0d, want %0d",
             $time, result_index, what, got, want);
  endtask

  // open a hole at slot and drop the new record in
  task automatic place_record(input int unsigned slot, input item_t it);
    for (int unsigned i = list_len; i > slot; i--) begin
      list_rec[i] = list_rec[i - 1];
    end
    list_rec[slot].key      = it.key;
    list_rec[slot].age      = it.age;
    list_rec[slot].children = it.children;
    list_len++;
  endtask

  // close the gap left at slot
  task automatic drop_record(input int unsigned slot);
    for (int unsigned i = slot; i + 1 < list_len; i++) begin
      list_rec[i] = list_rec[i + 1];
    end
    list_len--;
  endtask

  // first slot holding key, list_len on a miss
  function automatic int unsigned locate_key(input logic signed [31:0] key);
    for (int unsigned i = 0; i < list_len; i++) begin
      if (list_rec[i].key == key) return i;
    end
    return list_len;
  endfunction

  // apply one item to the shadow list and work out its reply
  task automatic apply_action(input item_t it, output result_t res);
    status_e     st;
    int unsigned found;
    int unsigned slot;
    st    = STAT_OK;
    found = 0;
    case (it.action)
      ACT_APPEND: begin
        if (list_len >= CAPACITY) st = STAT_FULL;
        else place_record(list_len, it);
      end
      ACT_INSERT: begin
        if (list_len >= CAPACITY) begin
          st = STAT_FULL;
        end else begin
          // goes before the first key not smaller, so it goes ahead of an equal head key
          slot = 0;
          while (slot < list_len && $signed(list_rec[slot].key) < $signed(it.key)) slot++;
          place_record(slot, it);
        end
      end
      ACT_SEARCH: begin
        slot = locate_key(it.key);
        if (slot < list_len) found = slot;
        else st = STAT_MISS;
      end
      ACT_DEL_POS: begin
        if (it.position < list_len) drop_record(it.position);
        else st = STAT_RANGE;
      end
      ACT_DEL_KEY: begin
        slot = locate_key(it.key);
        if (slot < list_len) drop_record(slot);
        else st = STAT_MISS;
      end
      ACT_CLEAR: begin
        list_len = 0;
      end
      default: begin
        // spare codes leave the list alone
      end
    endcase
    res.status         = st;
    res.found_position = found[4:0];
    res.entry_total    = list_len[5:0];
    res.is_empty       = (list_len == 0);
  endtask

  // results first, then the newly accepted item
  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    if (!rst_ni) begin
      list_len       = 0;
      mismatch_total = 0;
      result_index   = 0;
      reply_q.delete();
      pending_o      <= 0;
      fail_count_o   <= 0;
    end else begin
      if (done_i) begin
        if (reply_q.size() == 0) begin
          flag_mismatch("result with no item waiting", result_i, 0);
        end else begin
          want = reply_q.pop_front();
          if (result_i.status !== want.status)
            flag_mismatch("status", result_i.status, want.status);
          if (result_i.found_position !== want.found_position)
            flag_mismatch("found_position", result_i.found_position, want.found_position);
          if (result_i.entry_total !== want.entry_total)
            flag_mismatch("entry_total", result_i.entry_total, want.entry_total);
          if (result_i.is_empty !== want.is_empty)
            flag_mismatch("is_empty", result_i.is_empty, want.is_empty);
        end
        result_index++;
      end
      if (start_i && !busy_i) begin
        apply_action(item_i, want);
        reply_q.push_back(want);
      end
      pending_o    <= reply_q.size();
      fail_count_o <= mismatch_total + reply_q.size();
    end
  end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import rle_pkg::*;

  // codes the block treats as no-ops
  localparam logic [2:0] ACT_RSVD_A = 3'd6;
  localparam logic [2:0] ACT_RSVD_B = 3'd7;

  localparam int RANDOM_ITEMS = 1250;
  localparam int DRAIN_LIMIT  = 4000;

  localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;

  // random mix styles
  localparam int MIX_GROW   = 0;
  localparam int MIX_SHRINK = 1;
  localparam int MIX_EVEN   = 2;

  logic    clk;
  logic    rst_n;
  logic    start;
  logic    busy;
  item_t   item;
  logic    done;
  result_t result;
  int      pending;
  int      fail_count;

  record_list_engine_unit dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .start    (start),
    .busy     (busy),
    .item_i   (item),
    .done_o   (done),
    .result_o (result)
  );

  record_list_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_i       (busy),
    .item_i       (item),
    .done_i       (done),
    .result_i     (result),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // 20 ns clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop
  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic item_t make_item(input logic [2:0] action, input logic signed [31:0] key,
                                      input logic [7:0] age, input logic [7:0] children,
                                      input logic [4:0] position);
    item_t it;
    it.action   = action;
    it.key      = key;
    it.age      = age;
    it.children = children;
    it.position = position;
    return it;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // small pool for hits, the extremes, and full-width noise
  function automatic logic signed [31:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return $signed($urandom_range(0, 15)) - 8;
    if (r < 70) begin
      case ($urandom_range(0, 3))
        0:       return KEY_MAX;
        1:       return KEY_MIN;
        2:       return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  // action weights depend on whether the list should fill up or drain
  function automatic logic [2:0] pick_action(input int mix);
    int r;
    int lim [6];
    case (mix)
      MIX_GROW:   lim = '{35, 75, 85, 91, 97, 98};
      MIX_SHRINK: lim = '{8, 18, 35, 65, 95, 97};
      default:    lim = '{20, 45, 65, 80, 95, 97};
    endcase
    r = $urandom_range(0, 99);
    if (r < lim[0]) return ACT_APPEND;
    if (r < lim[1]) return ACT_INSERT;
    if (r < lim[2]) return ACT_SEARCH;
    if (r < lim[3]) return ACT_DEL_POS;
    if (r < lim[4]) return ACT_DEL_KEY;
    if (r < lim[5]) return ACT_CLEAR;
    return $urandom_range(0, 1) ? ACT_RSVD_A : ACT_RSVD_B;
  endfunction

  // called at a rising edge; returns at the edge that takes the item
  task automatic send_item(input item_t it, input int gap, input bit drain);
    if (gap > 0 || drain) begin
      start <= 1'b0;
      if (drain) begin
        do @(posedge clk); while (pending != 0);
      end
      repeat (gap) @(posedge clk);
    end
    item  <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  initial begin : stimulus
    item_t plan [$];
    item_t it;
    int    mix;
    int    span;
    int    sent;
    int    waited;
    bit    calm;

    start = 1'b0;
    item  = '0;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list: misses, range error, clear
    plan.push_back(make_item(ACT_SEARCH,  32'sd5, 8'd0, 8'd0, 5'd0));
    plan.push_back(make_item(ACT_DEL_POS, 32'sd0, 8'd0, 8'd0, 5'd0));
    plan.push_back(make_item(ACT_DEL_KEY, 32'sd5, 8'd0, 8'd0, 5'd0));
    plan.push_back(make_item(ACT_CLEAR,   32'sd0, 8'd0, 8'd0, 5'd0));
    // appends with extreme keys and payloads, then inserts at the front
    plan.push_back(make_item(ACT_APPEND, KEY_MAX, 8'd255, 8'd0,   5'd31));
    plan.push_back(make_item(ACT_APPEND, KEY_MIN, 8'd0,   8'd255, 5'd0));
    plan.push_back(make_item(ACT_APPEND, 32'sd0,  8'd1,   8'd2,   5'd0));
    plan.push_back(make_item(ACT_INSERT, -32'sd1, 8'd3,   8'd4,   5'd0));
    plan.push_back(make_item(ACT_INSERT, -32'sd1, 8'd5,   8'd6,   5'd0));
    plan.push_back(make_item(ACT_CLEAR,  32'sd0,  8'd0,   8'd0,   5'd0));
    // sorted inserts: middle, equal head key, signed extremes at both ends
    plan.push_back(make_item(ACT_INSERT, 32'sd10, 8'd10, 8'd11, 5'd0));
    plan.push_back(make_item(ACT_INSERT, 32'sd20, 8'd20, 8'd21, 5'd0));
    plan.push_back(make_item(ACT_INSERT, 32'sd15, 8'd15, 8'd16, 5'd0));
    plan.push_back(make_item(ACT_INSERT, 32'sd10, 8'd12, 8'd13, 5'd0));
    plan.push_back(make_item(ACT_INSERT, KEY_MIN, 8'd255, 8'd255, 5'd0));
    plan.push_back(make_item(ACT_INSERT, KEY_MAX, 8'd0,   8'd0,   5'd0));
    // searches: hit in the middle, hit at the tail, miss
    plan.push_back(make_item(ACT_SEARCH, 32'sd15, 8'd0, 8'd0, 5'd0));
    plan.push_back(make_item(ACT_SEARCH, KEY_MAX, 8'd0, 8'd0, 5'd0));
    plan.push_back(make_item(ACT_SEARCH, 32'sd99, 8'd0, 8'd0, 5'd0));
    // deletes: out of range, head, by key, by key miss
    plan.push_back(make_item(ACT_DEL_POS, 32'sd0,  8'd0, 8'd0, 5'd31));
    plan.push_back(make_item(ACT_DEL_POS, 32'sd0,  8'd0, 8'd0, 5'd0));
    plan.push_back(make_item(ACT_DEL_KEY, 32'sd20, 8'd0, 8'd0, 5'd0));
    plan.push_back(make_item(ACT_DEL_KEY, 32'sd99, 8'd0, 8'd0, 5'd0));
    // spare codes
    plan.push_back(make_item(ACT_RSVD_A, 32'sd15, 8'd1, 8'd1, 5'd1));
    plan.push_back(make_item(ACT_RSVD_B, 32'sd15, 8'd1, 8'd1, 5'd1));

    foreach (plan[i]) send_item(plan[i], pick_gap(), 1'b0);

    // random runs, each with its own mix; some start from a drained block
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      mix  = $urandom_range(MIX_GROW, MIX_EVEN);
      span = $urandom_range(20, 120);
      calm = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < span && sent < RANDOM_ITEMS; n++) begin
        it.action   = pick_action(mix);
        it.key      = pick_key();
        it.age      = 8'($urandom_range(0, 255));
        it.children = 8'($urandom_range(0, 255));
        it.position = 5'($urandom_range(0, 1) ? $urandom_range(0, 31) : $urandom_range(0, 3));
        send_item(it, calm ? 0 : pick_gap(),
                  n == 0 && (sent == 0 || $urandom_range(0, 3) == 0));
        sent++;
      end
    end

    // let the last results come in, then a quiet stretch
    start  <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending != 0 && waited < DRAIN_LIMIT);
    repeat (2 * CAPACITY) @(posedge clk);
    @(negedge clk);

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/rle_pkg.sv
rtl/core/rle_ram.sv
rtl/core/rle_ctrl.sv
rtl/core/record_list_engine_unit.sv
tb/sv/record_list_checker.sv
tb/sv/tb_top.sv
